[design/nddi_pkg.sv]
// Shared types, codes and saturating Q16.16 helpers for the Newton
// divided-difference interpolator. No dependencies.
`default_nettype none
package nddi_pkg;

  localparam int unsigned RESULT_LIMIT = 8;
  localparam logic [31:0] Q_ONE        = 32'h0001_0000;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DUP = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;
  localparam logic [1:0] ST_PTS = 2'd3;

  // condition bits carried with each coefficient: [1] saturated, [0] duplicate x
  localparam int unsigned COND_DUP = 0;
  localparam int unsigned COND_SAT = 1;

  typedef struct packed {
    logic        sat;
    logic [31:0] v;
  } sat_t;

  // datapath commands from the controller
  typedef struct packed {
    logic pt_we;    // store one point
    logic cap_xq;   // capture query abscissa
    logic do_sub;   // form numerator and denominator
    logic div_go;   // start division
    logic dd_we;    // write back divided difference
    logic ev_init;  // order-0 estimate
    logic ev_sub;   // term times (xq - x)
    logic ev_term;  // scale and saturate term
    logic ev_mul;   // coefficient times term
    logic ev_est;   // accumulate estimate
    logic ev_chg;   // step change
    logic out_ld;   // load result register
    logic zero_ld;  // load empty-set result
    logic last;     // result is highest order
    logic drop;     // points were dropped
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } stat_t;

  function automatic sat_t sat_w(input logic signed [63:0] v);
    sat_t r;
    if (v > 64'sd2147483647) begin
      r.sat = 1'b1;
      r.v   = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r.sat = 1'b1;
      r.v   = 32'h8000_0000;
    end else begin
      r.sat = 1'b0;
      r.v   = v[31:0];
    end
    return r;
  endfunction

  function automatic sat_t sub32(input logic [31:0] a, input logic [31:0] b);
    logic signed [63:0] d;
    d = $signed({{32{a[31]}}, a}) - $signed({{32{b[31]}}, b});
    return sat_w(d);
  endfunction

  function automatic sat_t add32(input logic [31:0] a, input logic [31:0] b);
    logic signed [63:0] s;
    s = $signed({{32{a[31]}}, a}) + $signed({{32{b[31]}}, b});
    return sat_w(s);
  endfunction

  // Q16.16 rescale of a full product, truncated toward zero
  function automatic sat_t mulq(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p[63] ? p + 64'sd65535 : p;
    t = t >>> 16;
    return sat_w(t);
  endfunction

endpackage
`default_nettype wire

[design/nddi_div.sv]
// Bit-serial signed Q16.16 divider, one quotient bit per cycle.
// Saturates its own quotient; uses no other file.
`default_nettype none
module nddi_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic        dup_o,
  output logic        sat_o
);

  localparam int unsigned DW = 48;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [5:0]    cnt_q, cnt_d;
  logic [DW-1:0] dvd_q, dvd_d;
  logic [31:0]   rem_q, rem_d;
  logic [31:0]   dvs_q, dvs_d;
  logic          neg_q, neg_d;
  logic [31:0]   quo_q, quo_d;
  logic          dup_q, dup_d;
  logic          sat_q, sat_d;
  logic [32:0]   rem_sh;
  logic          ge;
  logic [DW-1:0] qn;
  logic [31:0]   amag, bmag;

  always_comb begin
    amag   = num_i[31] ? 32'(-num_i) : num_i;
    bmag   = den_i[31] ? 32'(-den_i) : den_i;
    rem_sh = {rem_q, dvd_q[DW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    qn     = {dvd_q[DW-2:0], ge};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    quo_d  = quo_q;
    dup_d  = dup_q;
    sat_d  = sat_q;
    // launch: zero divisor finishes at once
    if (start_i) begin
      if (den_i == 32'd0) begin
        done_d = 1'b1;
        dup_d  = 1'b1;
        sat_d  = 1'b0;
        quo_d  = num_i[31] ? 32'h8000_0000 :
                 (num_i == 32'd0) ? 32'd0 : 32'h7FFF_FFFF;
      end else begin
        busy_d = 1'b1;
        cnt_d  = 6'(DW);
        dvd_d  = {amag, 16'h0000};
        rem_d  = 32'd0;
        dvs_d  = bmag;
        neg_d  = num_i[31] ^ den_i[31];
        dup_d  = 1'b0;
      end
    end else if (busy_q) begin
      // advance one restoring step
      rem_d = ge ? 32'(rem_sh - {1'b0, dvs_q}) : rem_sh[31:0];
      dvd_d = qn;
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (neg_q) begin
          sat_d = qn > 48'h0000_8000_0000;
          quo_d = sat_d ? 32'h8000_0000 : 32'(-qn);
        end else begin
          sat_d = qn > 48'h0000_7FFF_FFFF;
          quo_d = sat_d ? 32'h7FFF_FFFF : qn[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
    quo_q <= quo_d;
    dup_q <= dup_d;
    sat_q <= sat_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign dup_o  = dup_q;
  assign sat_o  = sat_q;

endmodule
`default_nettype wire

[design/nddi_datapath.sv]
// Point stores, divided-difference and evaluation arithmetic, result register.
// Depends on nddi_pkg and nddi_div.
`default_nettype none
module nddi_datapath #(
  parameter int unsigned MAX_POINTS = 8,
  parameter int unsigned AW         = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nddi_pkg::cmd_t       cmd_i,
  output nddi_pkg::stat_t      stat_o,
  input  logic [AW-1:0]        ra_i,
  input  logic [AW-1:0]        rb_i,
  input  logic [AW-1:0]        rc_i,
  input  logic [AW-1:0]        wa_i,
  input  logic [2:0]           ord_i,
  input  logic [31:0]          point_x_i,
  input  logic [31:0]          point_y_i,
  input  logic [31:0]          query_x_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           poly_order_o,
  output logic [31:0]          estimate_o,
  output logic [31:0]          step_change_o,
  output logic [1:0]           status_o,
  output logic                 last_result_o
);

  logic [31:0] x_mem [MAX_POINTS];
  logic [33:0] d_mem [MAX_POINTS];
  logic [31:0] x_a_q, x_c_q;
  logic [33:0] d_a_q, d_b_q;

  logic [31:0] num_q, den_q;
  logic [1:0]  c_q;
  logic [31:0] xq_q, term_q, est_q, prev_q, chg_q;
  logic [1:0]  cond_q;
  logic signed [63:0] prod_q;

  logic        div_done, div_dup, div_sat;
  logic [31:0] div_quo;

  logic        ov_q;
  logic [2:0]  ord_q;
  logic [31:0] oest_q, ochg_q;
  logic [1:0]  ost_q;
  logic        olast_q;

  nddi_pkg::sat_t sn, sd, se, sm, sa, sc;
  logic [1:0] st;

  // stores: one write port, registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.pt_we) begin
      x_mem[wa_i] <= point_x_i;
      d_mem[wa_i] <= {2'b00, point_y_i};
    end else if (cmd_i.dd_we) begin
      d_mem[wa_i] <= {c_q | {div_sat, div_dup}, div_quo};
    end
    x_a_q <= x_mem[ra_i];
    x_c_q <= x_mem[rc_i];
    d_a_q <= d_mem[ra_i];
    d_b_q <= d_mem[rb_i];
  end

  nddi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_go),
    .num_i  (num_q),
    .den_i  (den_q),
    .done_o (div_done),
    .quo_o  (div_quo),
    .dup_o  (div_dup),
    .sat_o  (div_sat)
  );

  always_comb begin
    sn = nddi_pkg::sub32(d_a_q[31:0], d_b_q[31:0]);
    sd = nddi_pkg::sub32(x_a_q, x_c_q);
    se = nddi_pkg::sub32(xq_q, x_c_q);
    sm = nddi_pkg::mulq(prod_q);
    sa = nddi_pkg::add32(est_q, sm.v);
    sc = nddi_pkg::sub32(est_q, prev_q);
    if (cmd_i.drop)                        st = nddi_pkg::ST_PTS;
    else if (cond_q[nddi_pkg::COND_DUP])   st = nddi_pkg::ST_DUP;
    else if (cond_q[nddi_pkg::COND_SAT])   st = nddi_pkg::ST_SAT;
    else                                   st = nddi_pkg::ST_OK;
  end

  // arithmetic registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_xq) xq_q <= query_x_i;
    if (cmd_i.do_sub) begin
      num_q <= sn.v;
      den_q <= sd.v;
      c_q   <= d_a_q[33:32] | d_b_q[33:32] | {sn.sat | sd.sat, 1'b0};
    end
    if (cmd_i.ev_init) begin
      est_q  <= d_a_q[31:0];
      cond_q <= d_a_q[33:32];
      term_q <= nddi_pkg::Q_ONE;
      chg_q  <= 32'd0;
    end
    if (cmd_i.ev_sub) begin
      cond_q <= cond_q | d_a_q[33:32] | {se.sat, 1'b0};
      prod_q <= 64'($signed(term_q)) * 64'($signed(se.v));
    end
    if (cmd_i.ev_term) begin
      term_q <= sm.v;
      cond_q <= cond_q | {sm.sat, 1'b0};
    end
    if (cmd_i.ev_mul) prod_q <= 64'($signed(d_a_q[31:0])) * 64'($signed(term_q));
    if (cmd_i.ev_est) begin
      prev_q <= est_q;
      est_q  <= sa.v;
      cond_q <= cond_q | {sm.sat | sa.sat, 1'b0};
    end
    if (cmd_i.ev_chg) begin
      chg_q  <= sc.v;
      cond_q <= cond_q | {sc.sat, 1'b0};
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.zero_ld) begin
      ord_q   <= 3'd0;
      oest_q  <= 32'd0;
      ochg_q  <= 32'd0;
      ost_q   <= nddi_pkg::ST_PTS;
      olast_q <= 1'b1;
    end else if (cmd_i.out_ld) begin
      ord_q   <= ord_i;
      oest_q  <= est_q;
      ochg_q  <= chg_q;
      ost_q   <= st;
      olast_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.out_ld || cmd_i.zero_ld) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !ov_q || out_ready_i;
  assign out_valid_o     = ov_q;
  assign poly_order_o    = ord_q;
  assign estimate_o      = oest_q;
  assign step_change_o   = ochg_q;
  assign status_o        = ost_q;
  assign last_result_o   = olast_q;

endmodule
`default_nettype wire

[design/nddi_ctrl.sv]
// Controller: point count, table-build and evaluation sequencing.
// Depends on nddi_pkg.
`default_nettype none
module nddi_ctrl #(
  parameter int unsigned MAX_POINTS = 8,
  parameter int unsigned AW         = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             req_type_i,
  input  nddi_pkg::stat_t  stat_i,
  output nddi_pkg::cmd_t   cmd_o,
  output logic [AW-1:0]    ra_o,
  output logic [AW-1:0]    rb_o,
  output logic [AW-1:0]    rc_o,
  output logic [AW-1:0]    wa_o,
  output logic [2:0]       ord_o
);

  localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned LIM = (MAX_POINTS > nddi_pkg::RESULT_LIMIT) ?
                                nddi_pkg::RESULT_LIMIT : MAX_POINTS;

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_DD_RD   = 15'b000000000000010,
    S_DD_SUB  = 15'b000000000000100,
    S_DD_DIV  = 15'b000000000001000,
    S_DD_WAIT = 15'b000000000010000,
    S_EV0_RD  = 15'b000000000100000,
    S_EV0     = 15'b000000001000000,
    S_EV_RD   = 15'b000000010000000,
    S_EV_SUB  = 15'b000000100000000,
    S_EV_TERM = 15'b000001000000000,
    S_EV_MUL  = 15'b000010000000000,
    S_EV_EST  = 15'b000100000000000,
    S_EV_CHG  = 15'b001000000000000,
    S_EV_OUT  = 15'b010000000000000,
    S_ZERO    = 15'b100000000000000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, n_eff;
  logic          drop_q, drop_d;
  logic [AW-1:0] i_q, i_d, j_q, j_d, nm1_q, nm1_d;
  logic          acc;

  always_comb begin
    acc     = in_valid_i && (state_q == S_IDLE);
    n_eff   = (cnt_q > CW'(LIM)) ? CW'(LIM) : cnt_q;
    state_d = state_q;
    cnt_d   = cnt_q;
    drop_d  = drop_q;
    i_d     = i_q;
    j_d     = j_q;
    nm1_d   = nm1_q;
    cmd_o   = '0;
    cmd_o.last = (i_q == nm1_q);
    cmd_o.drop = drop_q;
    case (state_q)
      // take requests: store points, flag a drop when full, or start an evaluation
      S_IDLE: begin
        if (acc) begin
          if (req_type_i == nddi_pkg::REQ_LOAD) begin
            if (cnt_q < CW'(MAX_POINTS)) begin
              cmd_o.pt_we = 1'b1;
              cnt_d       = cnt_q + CW'(1);
            end else begin
              drop_d = 1'b1;
            end
          end else begin
            cmd_o.cap_xq = 1'b1;
            nm1_d        = AW'(n_eff - CW'(1));
            if (cnt_q == CW'(0)) begin
              state_d = S_ZERO;
            end else if (n_eff == CW'(1)) begin
              i_d     = '0;
              state_d = S_EV0_RD;
            end else begin
              j_d     = AW'(1);
              i_d     = AW'(n_eff - CW'(1));
              state_d = S_DD_RD;
            end
          end
        end
      end
      S_DD_RD:  state_d = S_DD_SUB;
      S_DD_SUB: begin
        cmd_o.do_sub = 1'b1;
        state_d      = S_DD_DIV;
      end
      S_DD_DIV: begin
        cmd_o.div_go = 1'b1;
        state_d      = S_DD_WAIT;
      end
      // await the quotient, write back, then step down the column, to the next column or to evaluation
      S_DD_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.dd_we = 1'b1;
          if (i_q == j_q) begin
            if (j_q == nm1_q) begin
              i_d     = '0;
              state_d = S_EV0_RD;
            end else begin
              j_d     = j_q + AW'(1);
              i_d     = nm1_q;
              state_d = S_DD_RD;
            end
          end else begin
            i_d     = i_q - AW'(1);
            state_d = S_DD_RD;
          end
        end
      end
      S_EV0_RD: state_d = S_EV0;
      S_EV0: begin
        cmd_o.ev_init = 1'b1;
        state_d       = S_EV_OUT;
      end
      S_EV_RD:  state_d = S_EV_SUB;
      S_EV_SUB: begin
        cmd_o.ev_sub = 1'b1;
        state_d      = S_EV_TERM;
      end
      S_EV_TERM: begin
        cmd_o.ev_term = 1'b1;
        state_d       = S_EV_MUL;
      end
      S_EV_MUL: begin
        cmd_o.ev_mul = 1'b1;
        state_d      = S_EV_EST;
      end
      S_EV_EST: begin
        cmd_o.ev_est = 1'b1;
        state_d      = S_EV_CHG;
      end
      S_EV_CHG: begin
        cmd_o.ev_chg = 1'b1;
        state_d      = S_EV_OUT;
      end
      // hold until the result register frees up
      S_EV_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          if (i_q == nm1_q) begin
            cnt_d   = '0;
            drop_d  = 1'b0;
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + AW'(1);
            state_d = S_EV_RD;
          end
        end
      end
      S_ZERO: begin
        if (stat_i.out_free) begin
          cmd_o.zero_ld = 1'b1;
          cnt_d         = '0;
          drop_d        = 1'b0;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      nm1_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      i_q     <= i_d;
      j_q     <= j_d;
      nm1_q   <= nm1_d;
    end
  end

  // store addresses follow the loop counters
  assign ra_o       = i_q;
  assign rb_o       = i_q - AW'(1);
  assign rc_o       = (state_q == S_DD_RD || state_q == S_DD_SUB) ? i_q - j_q : i_q - AW'(1);
  assign wa_o       = (state_q == S_IDLE) ? cnt_q[AW-1:0] : i_q;
  assign ord_o      = 3'(i_q);
  assign in_ready_o = (state_q == S_IDLE);

endmodule
`default_nettype wire

[design/newton_divided_difference_interp.sv]
// Newton divided-difference interpolator, signed Q16.16.
// Slave channel takes load and evaluate requests; master channel returns one
// result per polynomial order, tlast on the highest order.
// Load: accepted with no result. Evaluate over n points: the table build runs
// n(n-1)/2 divisions (bit-serial divider, 48 quotient bits; the serial steps
// are skipped when two abscissas are equal), then each order past 0 steps
// through read, subtract, term, multiply, estimate and change, and each result
// waits for the master register to free. No request is taken until the last
// result of an evaluation is in the master register.
// A receiver stall holds the current result and freezes the sequencer at the
// next result. Reset empties the point count and clears the dropped flag; the
// point stores are not cleared and are only read below the count.
// Depends on nddi_pkg, nddi_ctrl, nddi_datapath, nddi_div.
`default_nettype none
module newton_divided_difference_interp #(
  parameter int unsigned MAX_POINTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] point_x, [63:32] point_y, [95:64] query_x
  input  logic [95:0] s_axis_tdata,
  // [0] req_type
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] poly_order, [34:3] estimate, [66:35] step_change, [68:67] status
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int unsigned AW = $clog2(MAX_POINTS);

  nddi_pkg::cmd_t  cmd;
  nddi_pkg::stat_t stat;
  logic [AW-1:0]   ra, rb, rc, wa;
  logic [2:0]      ord, poly_order;
  logic [31:0]     estimate, step_change;
  logic [1:0]      status;

  nddi_ctrl #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .req_type_i(s_axis_tuser),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .ra_o      (ra),
    .rb_o      (rb),
    .rc_o      (rc),
    .wa_o      (wa),
    .ord_o     (ord)
  );

  nddi_datapath #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .ra_i         (ra),
    .rb_i         (rb),
    .rc_i         (rc),
    .wa_i         (wa),
    .ord_i        (ord),
    .point_x_i    (s_axis_tdata[31:0]),
    .point_y_i    (s_axis_tdata[63:32]),
    .query_x_i    (s_axis_tdata[95:64]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .poly_order_o (poly_order),
    .estimate_o   (estimate),
    .step_change_o(step_change),
    .status_o     (status),
    .last_result_o(m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, status, step_change, estimate, poly_order};

`ifndef NO_ASSERTIONS
  // result register is only loaded when it is free
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_ld || cmd.zero_ld) |-> stat.out_free)
    else $error("result loaded over a pending one");
  // no request is taken while a division is launched
  a_no_req_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_go |-> !s_axis_tready)
    else $error("request accepted during table build");
  // write-back only with a finished quotient
  a_wb_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.dd_we |-> stat.div_done)
    else $error("divided difference written without quotient");
  // a division launch never repeats back to back
  a_div_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_go |=> !cmd.div_go)
    else $error("division restarted");
`endif

endmodule
`default_nettype wire

[dv/newton_divided_difference_interp_tb.sv]
// Testbench for the Newton divided-difference interpolator: drives load and
// evaluate requests, predicts every result in Q16.16 and checks each field.
// Depends on nddi_pkg and newton_divided_difference_interp.
`timescale 1ns / 100ps
module newton_divided_difference_interp_tb;

  localparam int unsigned NPTS    = 8;
  localparam longint      S32_HI  = 64'sd2147483647;
  localparam longint      S32_LO  = -64'sd2147483648;
  localparam int unsigned DRAIN   = 2000;

  typedef struct {
    logic [2:0]  order;
    logic [31:0] est;
    logic [31:0] chg;
    logic [1:0]  status;
    logic        last;
  } interp_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        s_axis_tuser = nddi_pkg::REQ_LOAD;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;

  // predictor state
  longint      pt_x[NPTS];
  longint      pt_dd[NPTS];
  int unsigned pt_count;
  bit          pt_dropped;

  interp_result_t expected_results[$];
  int unsigned    n_mismatch = 0;
  int unsigned    n_results = 0;
  int unsigned    n_requests = 0;
  int unsigned    n_evals = 0;
  bit             sender_idle_en = 1'b1;
  bit             receiver_idle_en = 1'b1;
  int unsigned    hold_cycles = 0;

  newton_divided_difference_interp #(.MAX_POINTS(NPTS)) DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // saturating Q16.16 arithmetic; cond[0] duplicate x, cond[1] saturated
  function automatic longint clamp32(longint v, inout bit [1:0] cond);
    if (v > S32_HI) begin
      cond[1] = 1'b1;
      return S32_HI;
    end
    if (v < S32_LO) begin
      cond[1] = 1'b1;
      return S32_LO;
    end
    return v;
  endfunction

  function automatic longint fx_sub(longint a, longint b, inout bit [1:0] cond);
    return clamp32(a - b, cond);
  endfunction

  function automatic longint fx_mul(longint a, longint b, inout bit [1:0] cond);
    return clamp32((a * b) / 65536, cond);
  endfunction

  function automatic longint fx_div(longint a, longint b, inout bit [1:0] cond);
    if (b == 0) begin
      cond[0] = 1'b1;
      if (a > 0) return S32_HI;
      if (a < 0) return S32_LO;
      return 0;
    end
    return clamp32((a * 65536) / b, cond);
  endfunction

  function automatic logic [1:0] status_code(bit [1:0] cond);
    if (pt_dropped) return nddi_pkg::ST_PTS;
    if (cond[0]) return nddi_pkg::ST_DUP;
    if (cond[1]) return nddi_pkg::ST_SAT;
    return nddi_pkg::ST_OK;
  endfunction

  // update the point store or compute every result of one evaluation
  function automatic void predict_interp(logic typ, logic [31:0] px, logic [31:0] py,
                                         logic [31:0] qx);
    bit [1:0]       flg[NPTS];
    bit [1:0]       c;
    bit [1:0]       cond;
    int             n;
    longint         num, den, est, term, prev, chg, xq;
    interp_result_t r;
    if (typ == nddi_pkg::REQ_LOAD) begin
      if (pt_count < NPTS) begin
        pt_x[pt_count]  = longint'($signed(px));
        pt_dd[pt_count] = longint'($signed(py));
        pt_count++;
      end else begin
        pt_dropped = 1'b1;
      end
      return;
    end
    n = (pt_count > nddi_pkg::RESULT_LIMIT) ? nddi_pkg::RESULT_LIMIT : pt_count;
    if (n == 0) begin
      r = '{3'd0, 32'd0, 32'd0, nddi_pkg::ST_PTS, 1'b1};
      expected_results.push_back(r);
    end else begin
      for (int i = 0; i < n; i++) flg[i] = 2'b00;
      // in-place table: entry k becomes f[x0..xk]
      for (int j = 1; j < n; j++) begin
        for (int i = n - 1; i >= j; i--) begin
          c = flg[i] | flg[i-1];
          num = fx_sub(pt_dd[i], pt_dd[i-1], c);
          den = fx_sub(pt_x[i], pt_x[i-j], c);
          pt_dd[i] = fx_div(num, den, c);
          flg[i] = c;
        end
      end
      xq = longint'($signed(qx));
      cond = flg[0];
      est = pt_dd[0];
      term = 65536;
      r = '{3'd0, est[31:0], 32'd0, status_code(cond), n == 1};
      expected_results.push_back(r);
      for (int i = 1; i < n; i++) begin
        cond |= flg[i];
        term = fx_mul(term, fx_sub(xq, pt_x[i-1], cond), cond);
        prev = est;
        est = clamp32(prev + fx_mul(pt_dd[i], term, cond), cond);
        chg = fx_sub(est, prev, cond);
        r = '{i[2:0], est[31:0], chg[31:0], status_code(cond), i == n - 1};
        expected_results.push_back(r);
      end
    end
    pt_count = 0;
    pt_dropped = 1'b0;
    n_evals++;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] %s mismatch: got %h want %h", $realtime, what, got, want);
    n_mismatch++;
  endtask

  // offer one request, hold it until the block takes it
  task automatic send_request(logic typ, logic [31:0] px, logic [31:0] py,
                              logic [31:0] qx);
    int unsigned gap;
    gap = sender_idle_en ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= typ;
    s_axis_tdata  <= {qx, py, px};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_interp(typ, px, py, qx);
    n_requests++;
  endtask

  task automatic end_requests();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // abscissa near a grid so tables stay well conditioned, with rare wild values
  function automatic logic [31:0] rand_x(int k);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'(k * $urandom_range(1, 3) * 65536 - 4 * 65536 + $urandom_range(0, 65535));
  endfunction

  function automatic logic [31:0] rand_y();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
  endfunction

  // receiver: random stall before each result, or a long requested hold-off
  initial begin
    int unsigned stall;
    forever begin
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      stall = receiver_idle_en ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && rst_ni));
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    interp_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[34:3], 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[2:0] !== want.order)
          report_mismatch("poly_order", 32'(m_axis_tdata[2:0]), 32'(want.order));
        if (m_axis_tdata[34:3] !== want.est)
          report_mismatch("estimate", m_axis_tdata[34:3], want.est);
        if (m_axis_tdata[66:35] !== want.chg)
          report_mismatch("step_change", m_axis_tdata[66:35], want.chg);
        if (m_axis_tdata[68:67] !== want.status)
          report_mismatch("status", 32'(m_axis_tdata[68:67]), 32'(want.status));
        if (m_axis_tlast !== want.last)
          report_mismatch("last_result", 32'(m_axis_tlast), 32'(want.last));
      end
    end
  end

  // empty set, single point, equal abscissas, overflow, dropped points, extremes
  task automatic test_special_cases();
    send_request(nddi_pkg::REQ_EVAL, '0, '0, 32'h0001_0000);
    send_request(nddi_pkg::REQ_LOAD, 32'h0002_0000, 32'h0005_8000, '0);
    send_request(nddi_pkg::REQ_EVAL, '0, '0, 32'h0003_0000);
    send_request(nddi_pkg::REQ_LOAD, 32'h0001_0000, 32'h0001_0000, '0);
    send_request(nddi_pkg::REQ_LOAD, 32'h0001_0000, 32'h0004_0000, '0);
    send_request(nddi_pkg::REQ_EVAL, '0, '0, 32'h0002_0000);
    send_request(nddi_pkg::REQ_LOAD, 32'h0000_0000, 32'h8000_0000, '0);
    send_request(nddi_pkg::REQ_LOAD, 32'h0000_0001, 32'h7FFF_FFFF, '0);
    send_request(nddi_pkg::REQ_EVAL, '0, '0, 32'h7FFF_FFFF);
    for (int i = 0; i < 9; i++)
      send_request(nddi_pkg::REQ_LOAD, 32'(i * 65536), rand_y(), '0);
    send_request(nddi_pkg::REQ_EVAL, '0, '0, 32'h0004_8000);
    send_request(nddi_pkg::REQ_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, '0);
    send_request(nddi_pkg::REQ_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, '0);
    send_request(nddi_pkg::REQ_LOAD, 32'hFFFF_FFFF, 32'h0000_0000, '0);
    send_request(nddi_pkg::REQ_EVAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    end_requests();
    wait_drained();
  endtask

  // point sets of random size and content, with some stray requests of random type
  task automatic test_random_sets(int unsigned n_items);
    int unsigned sent, npts;
    sent = 0;
    while (sent < n_items) begin
      if (sent % 60 == 30) begin
        sender_idle_en = ~sender_idle_en;
        receiver_idle_en = ~receiver_idle_en;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_request(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
        sent++;
      end else begin
        npts = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 5);
        for (int k = 0; k < npts; k++)
          send_request(nddi_pkg::REQ_LOAD, rand_x(k), rand_y(), $urandom);
        send_request(nddi_pkg::REQ_EVAL, $urandom, $urandom,
                     rand_x(int'($urandom_range(0, 5))));
        sent += npts + 1;
      end
    end
    sender_idle_en = 1'b1;
    receiver_idle_en = 1'b1;
    end_requests();
    wait_drained();
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    hold_cycles = 3000;
    for (int e = 0; e < 3; e++) begin
      for (int k = 0; k < 4; k++)
        send_request(nddi_pkg::REQ_LOAD, rand_x(k), rand_y(), '0);
      send_request(nddi_pkg::REQ_EVAL, '0, '0, rand_x(2));
    end
    end_requests();
    wait_drained();
    for (int k = 0; k < 3; k++)
      send_request(nddi_pkg::REQ_LOAD, rand_x(k), rand_y(), '0);
    send_request(nddi_pkg::REQ_EVAL, '0, '0, rand_x(1));
    end_requests();
    wait_drained();
  endtask

  initial begin
    pt_count = 0;
    pt_dropped = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_cases();
    test_backpressure();
    test_random_sets(420);
    repeat (DRAIN) @(posedge clk_i);
    $display("Covered %0d requests, %0d evaluations, %0d results checked,",
             n_requests, n_evals, n_results);
    $display("including empty sets, equal abscissas, overflow, drops and stalls.");
    if (n_mismatch == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", n_mismatch,
               expected_results.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
